/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files, used by the steering top
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lfs_pkg.sv */
// types, register map and phase codes for the line follower steering block
// no dependencies
package lfs_pkg;

  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    REG_MAX_SPEED   = 3'd0,
    REG_RAMP_STEP   = 3'd1,
    REG_RAMP_INTVL  = 3'd2,
    REG_GENTLE_SPD  = 3'd3,
    REG_SHARP_SPD   = 3'd4,
    REG_PIVOT_REV   = 3'd5,
    REG_UNUSED6     = 3'd6,
    REG_UNUSED7     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_REFRESH = 3'd0,
    PH_FORWARD = 3'd1,
    PH_LEFT1   = 3'd2,
    PH_LEFT2   = 3'd3,
    PH_LEFT3   = 3'd4,
    PH_RIGHT1  = 3'd5,
    PH_RIGHT2  = 3'd6,
    PH_RIGHT3  = 3'd7
  } phase_t;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_PASS = 1'b1;

  localparam logic [7:0] RST_MAX_SPEED = 8'd200;
  localparam logic [5:0] RST_RAMP_STEP = 6'd3;
  localparam logic [6:0] RST_RAMP_INTVL = 7'd2;
  localparam logic [7:0] RST_GENTLE_SPD = 8'd40;
  localparam logic [7:0] RST_SHARP_SPD = 8'd20;
  localparam logic [7:0] RST_PIVOT_REV = 8'd40;

  typedef struct packed {
    logic [7:0] max_speed;
    logic [5:0] ramp_step;
    logic [6:0] ramp_interval;
    logic [7:0] gentle_turn_speed;
    logic [7:0] sharp_turn_speed;
    logic [7:0] pivot_reverse_speed;
  } cfg_t;

  // one ramp update of a forward speed toward its target
  function automatic logic [7:0] ramp_one(input logic [7:0] speed, input logic [7:0] target,
                                          input logic [7:0] max_spd, input logic [5:0] step);
    logic signed [9:0] sum;
    logic signed [9:0] ceil;
    logic [7:0] res;
    sum  = $signed({2'b00, speed}) + $signed({4'b0000, step});
    ceil = $signed({2'b00, max_spd}) - 10'sd2;
    res  = speed;
    if (target > speed) begin
      if (sum >= ceil) begin
        res = max_spd;
      end else begin
        res = sum[7:0];
      end
    end else if (target < speed) begin
      if (speed <= {2'b00, step}) begin
        res = 8'd0;
      end else begin
        res = speed - {2'b00, step};
      end
    end
    return res;
  endfunction

endpackage

/* hw/rtl/lfs_cfg_regs.sv */
// apb register file for the steering settings
// depends on lfs_pkg
module lfs_cfg_regs import lfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output cfg_t                cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CfgAddrW-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed           <= RST_MAX_SPEED;
      cfg_r.ramp_step           <= RST_RAMP_STEP;
      cfg_r.ramp_interval       <= RST_RAMP_INTVL;
      cfg_r.gentle_turn_speed   <= RST_GENTLE_SPD;
      cfg_r.sharp_turn_speed    <= RST_SHARP_SPD;
      cfg_r.pivot_reverse_speed <= RST_PIVOT_REV;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_SPEED:  cfg_r.max_speed           <= cfg_pwdata[7:0];
        REG_RAMP_STEP:  cfg_r.ramp_step           <= cfg_pwdata[5:0];
        REG_RAMP_INTVL: cfg_r.ramp_interval       <= cfg_pwdata[6:0];
        REG_GENTLE_SPD: cfg_r.gentle_turn_speed   <= cfg_pwdata[7:0];
        REG_SHARP_SPD:  cfg_r.sharp_turn_speed    <= cfg_pwdata[7:0];
        REG_PIVOT_REV:  cfg_r.pivot_reverse_speed <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_MAX_SPEED:  cfg_prdata = {24'd0, cfg_r.max_speed};
      REG_RAMP_STEP:  cfg_prdata = {26'd0, cfg_r.ramp_step};
      REG_RAMP_INTVL: cfg_prdata = {25'd0, cfg_r.ramp_interval};
      REG_GENTLE_SPD: cfg_prdata = {24'd0, cfg_r.gentle_turn_speed};
      REG_SHARP_SPD:  cfg_prdata = {24'd0, cfg_r.sharp_turn_speed};
      REG_PIVOT_REV:  cfg_prdata = {24'd0, cfg_r.pivot_reverse_speed};
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/line_follow_steer_ramp_top.sv */
// steering top: an item passes the input register, then the result register, and
// its result then sits on out_tdata; throughput one item per cycle, back to back,
// while the output is not stalled; a stall on out_tready holds both registers
// reset (synchronous, rst_n low) stops the run flag, clears speeds and duties,
// sets targets and settings to their defaults and empties both registers
// depends on lfs_pkg, lfs_cfg_regs and assert_macros.svh
`include "assert_macros.svh"
module line_follow_steer_ramp_top import lfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // [7:0] sensors, [8] button, rest zero
  input  logic [0:0]          in_tuser,   // [0] kind
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] left_forward_duty, [15:8] right_forward_duty, [23:16] left_reverse_duty,
  // [31:24] right_reverse_duty, [32] indicator, [33] running, rest zero
  output logic [39:0]         out_tdata,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  cfg_t cfg;

  lfs_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // input register
  logic       in_vld_r;
  logic       kind_r;
  logic [7:0] sensors_r;
  logic       button_r;
  logic       fire;

  assign fire      = in_vld_r & (~out_tvalid | out_tready);
  assign in_tready = ~in_vld_r | fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r    <= in_tuser[0];
      sensors_r <= in_tdata[7:0];
      button_r  <= in_tdata[8];
    end
  end

  // steering state
  logic              run_r, run_nxt;
  phase_t            phase_r, phase_nxt;
  logic signed [7:0] cnt_r, cnt_nxt;
  logic [7:0]        tgt_l_r, tgt_l_nxt, tgt_r_r, tgt_r_nxt;
  logic [7:0]        spd_l_r, spd_l_nxt, spd_r_r, spd_r_nxt;
  logic [7:0]        rev_l_r, rev_l_nxt, rev_r_r, rev_r_nxt;
  logic [7:0]        duty_r [4];
  logic [7:0]        duty_nxt [4];
  logic              led_r, led_nxt;

  always_comb begin
    run_nxt   = run_r | (kind_r == KIND_PASS && button_r);
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tgt_l_nxt = tgt_l_r;
    tgt_r_nxt = tgt_r_r;
    spd_l_nxt = spd_l_r;
    spd_r_nxt = spd_r_r;
    rev_l_nxt = rev_l_r;
    rev_r_nxt = rev_r_r;
    led_nxt   = led_r;
    for (int i = 0; i < 4; i++) begin
      duty_nxt[i] = duty_r[i];
    end

    if (kind_r == KIND_TICK) begin
      if (cnt_r != -8'sd128) begin
        cnt_nxt = cnt_r - 8'sd1;
      end
    end else if (run_nxt) begin
      if (phase_r == PH_REFRESH) begin
        if (cnt_r <= 8'sd0) begin
          spd_l_nxt = ramp_one(spd_l_r, tgt_l_r, cfg.max_speed, cfg.ramp_step);
          spd_r_nxt = ramp_one(spd_r_r, tgt_r_r, cfg.max_speed, cfg.ramp_step);
          cnt_nxt   = $signed({1'b0, cfg.ramp_interval});
        end
        duty_nxt[0] = spd_l_nxt;
        duty_nxt[1] = spd_r_nxt;
        duty_nxt[2] = rev_l_r;
        duty_nxt[3] = rev_r_r;
        // the first matching sensor rule wins
        priority if (sensors_r[0])                 phase_nxt = PH_RIGHT3;
        else if (sensors_r[1])                     phase_nxt = PH_RIGHT2;
        else if (sensors_r[2])                     phase_nxt = PH_RIGHT1;
        else if (sensors_r[7])                     phase_nxt = PH_LEFT3;
        else if (sensors_r[6])                     phase_nxt = PH_LEFT2;
        else if (sensors_r[5])                     phase_nxt = PH_LEFT1;
        else if (sensors_r[4] || sensors_r[3])     phase_nxt = PH_FORWARD;
        else                                       phase_nxt = PH_REFRESH;
      end else begin
        rev_l_nxt = 8'd0;
        rev_r_nxt = 8'd0;
        led_nxt   = 1'b1;
        tgt_l_nxt = cfg.max_speed;
        tgt_r_nxt = cfg.max_speed;
        unique case (phase_r)
          PH_FORWARD: led_nxt = 1'b0;
          PH_LEFT1:   tgt_l_nxt = cfg.gentle_turn_speed;
          PH_LEFT2:   tgt_l_nxt = cfg.sharp_turn_speed;
          PH_LEFT3: begin
            tgt_l_nxt = 8'd0;
            rev_l_nxt = cfg.pivot_reverse_speed;
          end
          PH_RIGHT1:  tgt_r_nxt = cfg.gentle_turn_speed;
          PH_RIGHT2:  tgt_r_nxt = cfg.sharp_turn_speed;
          PH_RIGHT3: begin
            tgt_r_nxt = 8'd0;
            rev_r_nxt = cfg.pivot_reverse_speed;
          end
          default: begin
            tgt_l_nxt = tgt_l_r;
            tgt_r_nxt = tgt_r_r;
            rev_l_nxt = rev_l_r;
            rev_r_nxt = rev_r_r;
            led_nxt   = led_r;
          end
        endcase
        phase_nxt = PH_REFRESH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      phase_r <= PH_REFRESH;
      cnt_r   <= $signed({1'b0, RST_RAMP_INTVL});
      tgt_l_r <= RST_MAX_SPEED;
      tgt_r_r <= RST_MAX_SPEED;
      spd_l_r <= 8'd0;
      spd_r_r <= 8'd0;
      rev_l_r <= 8'd0;
      rev_r_r <= 8'd0;
      led_r   <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        duty_r[i] <= 8'd0;
      end
    end else if (fire) begin
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      tgt_l_r <= tgt_l_nxt;
      tgt_r_r <= tgt_r_nxt;
      spd_l_r <= spd_l_nxt;
      spd_r_r <= spd_r_nxt;
      rev_l_r <= rev_l_nxt;
      rev_r_r <= rev_r_nxt;
      led_r   <= led_nxt;
      for (int i = 0; i < 4; i++) begin
        duty_r[i] <= duty_nxt[i];
      end
    end
  end

  // result register
  logic        out_vld_r;
  logic [39:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {6'd0, run_nxt, led_nxt, duty_nxt[3], duty_nxt[2],
                     duty_nxt[1], duty_nxt[0]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `LFS_ASSERT_NEXT(a_run_sticky, run_r, run_r, "run flag cleared without reset")
  `LFS_ASSERT_NOW(a_one_reverse, rev_l_r != 8'd0, rev_r_r == 8'd0,
    "both wheels driven in reverse")
  `LFS_ASSERT_NEXT(a_mode_returns, fire && kind_r == KIND_PASS && phase_r != PH_REFRESH,
    phase_r == PH_REFRESH, "mode pass did not return to refresh")
  `LFS_ASSERT_NOW(a_straight_targets, !led_r, tgt_l_r == tgt_r_r,
    "straight mode with unequal targets")

endmodule
